/* design/gamepad_sample_event_conditioner_defines.svh */
`ifndef GAMEPAD_SAMPLE_EVENT_CONDITIONER_DEFINES_SVH
`define GAMEPAD_SAMPLE_EVENT_CONDITIONER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define GSEC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define GSEC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/gsec_pkg.sv */
package gsec_pkg;

  localparam int BUTTON_COUNT = 12;
  localparam int NUM_AXES     = 6;
  localparam int AXIS_W       = 16;
  localparam int NUM_SLOTS    = BUTTON_COUNT + NUM_AXES;
  localparam int SLOT_W       = $clog2(NUM_SLOTS);

  localparam logic [1:0] REG_STICK_DZ   = 2'd0;
  localparam logic [1:0] REG_TRIGGER_DZ = 2'd1;

  localparam logic [2:0] AX_SIDE    = 3'd0;
  localparam logic [2:0] AX_FORWARD = 3'd1;
  localparam logic [2:0] AX_PITCH   = 3'd2;
  localparam logic [2:0] AX_YAW     = 3'd3;
  localparam logic [2:0] AX_LTRIG   = 3'd4;
  localparam logic [2:0] AX_RTRIG   = 3'd5;

  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_AXIS    = 2'd2
  } event_kind_t;

  typedef struct packed {
    logic                                 present;
    logic [BUTTON_COUNT-1:0]              buttons;
    logic [NUM_AXES-1:0][AXIS_W-1:0]      axis_val;
  } sample_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  typedef struct packed {
    logic idle;
    logic connected;
  } back_status_t;

endpackage

/* design/gsec_front.sv */
module gsec_front (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [1:0]             cfg_index,
  input  logic [7:0]             cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   pad_present,
  input  logic [11:0]            held_buttons,
  input  logic signed [7:0]      main_x,
  input  logic signed [7:0]      main_y,
  input  logic signed [7:0]      sub_x,
  input  logic signed [7:0]      sub_y,
  input  logic [7:0]             trigger_left,
  input  logic [7:0]             trigger_right,
  input  gsec_pkg::queue_status_t q_stat,
  output logic                   push_valid,
  output gsec_pkg::sample_t      push_item
);

  // ceil(32767 * 2^16 / 72) and ceil(32767 * 2^24 / 255)
  localparam logic [24:0] STICK_RECIP = 25'd29825252;
  localparam logic [31:0] TRIG_RECIP  = 32'd2155839360;

  logic [6:0]        stick_dz;
  logic [7:0]        trigger_dz;
  logic              f_valid;
  gsec_pkg::sample_t f_item;
  gsec_pkg::sample_t cond;
  logic              accept;
  logic              push;

  function automatic logic [7:0] neg_sat(input logic [7:0] v);
    return (v == 8'h80) ? 8'h7f : (~v + 8'd1);
  endfunction

  function automatic logic [15:0] stick_cond(input logic [7:0] v, input logic [6:0] dz);
    logic [7:0]  mag;
    logic [32:0] prod;
    logic [16:0] q;
    logic [15:0] r;
    mag  = v[7] ? (~v + 8'd1) : v;
    prod = 33'(mag) * 33'(STICK_RECIP);
    q    = prod[32:16];
    if (mag < {1'b0, dz}) begin
      r = '0;
    end else if (!v[7]) begin
      r = (q > 17'd32767) ? 16'h7fff : q[15:0];
    end else begin
      r = (q > 17'd32768) ? 16'h8000 : (~q[15:0] + 16'd1);
    end
    return r;
  endfunction

  function automatic logic [15:0] trigger_cond(input logic [7:0] t, input logic [7:0] dz);
    logic [39:0] prod;
    prod = 40'(t) * 40'(TRIG_RECIP);
    return (t < dz) ? 16'd0 : prod[39:24];
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_dz   <= 7'd8;
      trigger_dz <= 8'd15;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        gsec_pkg::REG_STICK_DZ:   stick_dz   <= cfg_data[6:0];
        gsec_pkg::REG_TRIGGER_DZ: trigger_dz <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    cond.present  = pad_present;
    cond.buttons  = held_buttons[gsec_pkg::BUTTON_COUNT-1:0];
    cond.axis_val = '0;
    cond.axis_val[gsec_pkg::AX_SIDE]    = stick_cond(main_x, stick_dz);
    cond.axis_val[gsec_pkg::AX_FORWARD] = stick_cond(neg_sat(main_y), stick_dz);
    cond.axis_val[gsec_pkg::AX_YAW]     = stick_cond(sub_x, stick_dz);
    cond.axis_val[gsec_pkg::AX_PITCH]   = stick_cond(neg_sat(sub_y), stick_dz);
    cond.axis_val[gsec_pkg::AX_LTRIG]   = trigger_cond(trigger_left, trigger_dz);
    cond.axis_val[gsec_pkg::AX_RTRIG]   = trigger_cond(trigger_right, trigger_dz);
  end

  assign push       = f_valid && !q_stat.full;
  assign in_stall   = f_valid && q_stat.full;
  assign accept     = in_valid && !in_stall;
  assign push_valid = f_valid;
  assign push_item  = f_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_item <= cond;
    end
  end

endmodule

/* design/gsec_queue.sv */
module gsec_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push_valid,
  input  gsec_pkg::sample_t       push_item,
  input  logic                    pop,
  output gsec_pkg::sample_t       pop_item,
  output gsec_pkg::queue_status_t q_stat
);

  gsec_pkg::sample_t mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic              do_pop;

  assign q_stat.full  = (count == 2'd2);
  assign q_stat.empty = (count == 2'd0);
  assign push         = push_valid && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign pop_item     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

/* design/gsec_back.sv */
module gsec_back (
  input  logic                    clk,
  input  logic                    rst,
  input  gsec_pkg::queue_status_t q_stat,
  input  gsec_pkg::sample_t       q_item,
  output logic                    pop,
  input  logic                    out_stall,
  output logic                    out_valid,
  output logic [1:0]              event_kind,
  output logic [3:0]              button_index,
  output logic [2:0]              axis_id,
  output logic signed [15:0]      axis_value,
  output logic                    last_event,
  output gsec_pkg::back_status_t  status
);

  localparam int NB = gsec_pkg::BUTTON_COUNT;
  localparam int NA = gsec_pkg::NUM_AXES;
  localparam int NS = gsec_pkg::NUM_SLOTS;

  logic                         was_connected;
  logic [NB-1:0]                last_buttons;
  logic [gsec_pkg::AXIS_W-1:0]  last_axis [NA];
  logic [NS-1:0]                pending;
  logic                         swap;

  logic [NS-1:0]                low_bit;
  logic                         single;
  logic [gsec_pkg::SLOT_W-1:0]  sel;
  logic                         issue;
  logic                         can_load;
  logic                         conn_new;
  logic                         active;
  logic [NB-1:0]                base_btn;
  logic [NB-1:0]                tgt_btn;
  logic [NA-1:0]                new_pend_ax;
  logic [2:0]                   sel_axis;
  gsec_pkg::event_kind_t        kind_next;

  function automatic logic [2:0] slot_axis(input logic [2:0] k, input logic sw);
    logic [2:0] a;
    a = k;
    if (sw && k == gsec_pkg::AX_PITCH) begin
      a = gsec_pkg::AX_YAW;
    end else if (sw && k == gsec_pkg::AX_YAW) begin
      a = gsec_pkg::AX_PITCH;
    end
    return a;
  endfunction

  // lowest pending slot goes next
  assign low_bit = pending & (~pending + NS'(1));
  assign single  = ((pending & (pending - NS'(1))) == '0);

  always_comb begin
    sel = '0;
    for (int i = NS - 1; i >= 0; i--) begin
      if (low_bit[i]) begin
        sel = gsec_pkg::SLOT_W'(i);
      end
    end
  end

  assign issue    = (pending != '0) && (!out_valid || !out_stall);
  assign can_load = (pending == '0) || (issue && single);
  assign pop      = can_load && !q_stat.empty;
  assign sel_axis = slot_axis(3'(sel - gsec_pkg::SLOT_W'(NB)), swap);

  always_comb begin
    if (sel < gsec_pkg::SLOT_W'(NB)) begin
      kind_next = last_buttons[sel[$clog2(NB)-1:0]] ? gsec_pkg::EV_PRESS
                                                     : gsec_pkg::EV_RELEASE;
    end else begin
      kind_next = gsec_pkg::EV_AXIS;
    end
  end

  assign conn_new = q_item.present && !was_connected;
  assign active   = q_item.present || was_connected;
  assign base_btn = conn_new ? '0 : last_buttons;
  assign tgt_btn  = q_item.present ? q_item.buttons : '0;

  always_comb begin
    for (int k = 0; k < NA; k++) begin
      logic [2:0]                  a;
      logic [gsec_pkg::AXIS_W-1:0] base_v;
      logic [gsec_pkg::AXIS_W-1:0] tgt_v;
      a      = slot_axis(3'(k), q_item.present);
      base_v = conn_new ? '0 : last_axis[a];
      tgt_v  = q_item.present ? q_item.axis_val[a] : '0;
      new_pend_ax[k] = active && (tgt_v != base_v);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_connected <= 1'b0;
      last_buttons  <= '0;
      pending       <= '0;
      swap          <= 1'b0;
      for (int a = 0; a < NA; a++) begin
        last_axis[a] <= '0;
      end
    end else if (pop) begin
      was_connected <= q_item.present;
      last_buttons  <= tgt_btn;
      swap          <= q_item.present;
      pending       <= {new_pend_ax, (active ? (tgt_btn ^ base_btn) : NB'(0))};
      for (int a = 0; a < NA; a++) begin
        last_axis[a] <= q_item.present ? q_item.axis_val[a] : '0;
      end
    end else if (issue) begin
      pending <= pending & ~low_bit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (issue) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      event_kind <= kind_next;
      last_event <= single;
      if (kind_next == gsec_pkg::EV_AXIS) begin
        button_index <= '0;
        axis_id      <= sel_axis;
        axis_value   <= last_axis[sel_axis];
      end else begin
        button_index <= 4'(sel);
        axis_id      <= '0;
        axis_value   <= '0;
      end
    end
  end

  assign status.idle      = (pending == '0);
  assign status.connected = was_connected;

endmodule

/* design/gamepad_sample_event_conditioner.sv */
// path: a sample passes the front register, the sample queue and the pending set to the registered event outputs
// events: a sample yields n events (at most 18); the next is loaded as the last event issues
// samples are taken every cycle while the 2-entry sample queue has room
// reset: synchronous, active high; clears connection, button and axis history, empties the queue
// reset: deadzones return to 8 (stick) and 15 (trigger); no clearing pass is needed
`include "gamepad_sample_event_conditioner_defines.svh"

module gamepad_sample_event_conditioner (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              pad_present,
  input  logic [11:0]       held_buttons,
  input  logic signed [7:0] main_x,
  input  logic signed [7:0] main_y,
  input  logic signed [7:0] sub_x,
  input  logic signed [7:0] sub_y,
  input  logic [7:0]        trigger_left,
  input  logic [7:0]        trigger_right,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        event_kind,
  output logic [3:0]        button_index,
  output logic [2:0]        axis_id,
  output logic signed [15:0] axis_value,
  output logic              last_event
);

  gsec_pkg::queue_status_t q_stat;
  gsec_pkg::sample_t       push_item;
  gsec_pkg::sample_t       pop_item;
  gsec_pkg::back_status_t  bk_stat;
  logic                    push_valid;
  logic                    pop;

  gsec_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pad_present   (pad_present),
    .held_buttons  (held_buttons),
    .main_x        (main_x),
    .main_y        (main_y),
    .sub_x         (sub_x),
    .sub_y         (sub_y),
    .trigger_left  (trigger_left),
    .trigger_right (trigger_right),
    .q_stat        (q_stat),
    .push_valid    (push_valid),
    .push_item     (push_item)
  );

  gsec_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_item  (push_item),
    .pop        (pop),
    .pop_item   (pop_item),
    .q_stat     (q_stat)
  );

  gsec_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_stat       (q_stat),
    .q_item       (pop_item),
    .pop          (pop),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .event_kind   (event_kind),
    .button_index (button_index),
    .axis_id      (axis_id),
    .axis_value   (axis_value),
    .last_event   (last_event),
    .status       (bk_stat)
  );

  `GSEC_ASSERT_IMP(a_key_fields, out_valid && event_kind != gsec_pkg::EV_AXIS, axis_id == 3'd0 && axis_value == 16'sd0, "key event carries axis data")
  `GSEC_ASSERT_IMP(a_axis_fields, out_valid && event_kind == gsec_pkg::EV_AXIS, button_index == 4'd0, "axis event carries a button index")
  `GSEC_ASSERT_NXT(a_no_spurious, out_valid && !out_stall && bk_stat.idle, !out_valid, "event issued with nothing pending")
  `GSEC_ASSERT_NXT(a_idle_disconnected, !bk_stat.connected && bk_stat.idle && !out_valid && q_stat.empty, !out_valid, "event while disconnected and idle")

endmodule
